FILE: src/assert_macros.svh
// Assertion macros for the RTL of the line draw and scanline fill block.
// Each macro expands to one labeled concurrent assertion, clocked and reset-qualified.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant violated");

// A consequence that holds in the same cycle as its trigger.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// A consequence that holds in the cycle after its trigger.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

FILE: src/ldsf_pkg.sv
// Package for the line draw and scanline fill block: field widths, command codes,
// colors and default grid size. No dependencies.
package ldsf_pkg;

  localparam int COORD_W = 6;
  localparam int COLOR_W = 4;
  localparam int CMD_W   = 2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [CMD_W-1:0]   cmd_t;

  localparam cmd_t CMD_MOVE  = 2'd0;
  localparam cmd_t CMD_FILL  = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;

  localparam color_t LINE_COLOR       = 4'd3;
  localparam color_t RESET_FILL_COLOR = 4'd15;

  localparam int GRID_WIDTH_DEF  = 64;
  localparam int GRID_HEIGHT_DEF = 64;

endpackage

FILE: src/ldsf_ifs.sv
// Valid/ready channel interfaces of the line draw and scanline fill block.
// Depends on ldsf_pkg for the payload types.
interface ldsf_cmd_if;
  logic              valid;
  logic              ready;
  ldsf_pkg::cmd_t    cmd;
  ldsf_pkg::coord_t  x;
  ldsf_pkg::coord_t  y;
  logic              draw;

  modport source (output valid, cmd, x, y, draw, input ready);
  modport sink   (input valid, cmd, x, y, draw, output ready);
endinterface

interface ldsf_pix_if;
  logic              valid;
  logic              ready;
  ldsf_pkg::coord_t  pixel_x;
  ldsf_pkg::coord_t  pixel_y;
  ldsf_pkg::color_t  pixel_color;
  logic              last;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

FILE: src/line_draw_scanline_fill_top.sv
// Line draw and scanline fill top level; uses ldsf_pkg, ldsf_ifs and assert_macros.svh.
// Line: pixels pass stepper, mark stage, output register; one per cycle unless the output
// stalls (one edge map RMW each). Fill: a scan of all columns, then one pixel per cycle
// unless the output stalls; clear: a pass over all rows. Reset (async, active low) clears
// point and control, sets fill color 15, and clears the edge map, taking no item meanwhile.
`include "assert_macros.svh"

module line_draw_scanline_fill_top #(
  parameter int GRID_WIDTH  = ldsf_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = ldsf_pkg::GRID_HEIGHT_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  ldsf_pkg::color_t       cfg_wdata_i,
  ldsf_cmd_if.sink               item_i,
  ldsf_pix_if.source             pixel_o
);

  // The edge map lives in one synchronous memory, one row of mark bits per
  // grid row. Line pixels pass through a two-stage path: the stepper issues
  // the row read, and the mark stage merges the pixel's bit into the returned
  // row and writes it back in its first cycle. The row written in the cycle
  // before is forwarded, since the memory read does not see it yet. A fill
  // reads its row once, scans the columns one a cycle into a span mask, and
  // then emits the set bits of that mask in ascending order.
  localparam int CW = $clog2(GRID_WIDTH);
  localparam int RW = $clog2(GRID_HEIGHT);

  typedef logic [GRID_WIDTH-1:0] bits_t;
  typedef logic [CW-1:0]         col_t;
  typedef logic [RW-1:0]         row_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_LINE,
    S_SCAN,
    S_EMIT
  } state_e;

  // Control and datapath registers.
  state_e            state_q;
  row_t              clr_q;
  ldsf_pkg::color_t  fill_color_q;
  ldsf_pkg::coord_t  cur_x_q, cur_y_q;

  // Line stepper.
  logic              xmaj_q, sx_neg_q, sx_nz_q, sy_neg_q, sy_nz_q;
  logic [6:0]        inc_q;
  logic signed [8:0] both_q, e_q;
  ldsf_pkg::coord_t  cnt_q;

  // Mark stage.
  logic              b_valid_q, b_fresh_q, b_last_q;
  ldsf_pkg::coord_t  b_x_q, b_y_q;

  // Write forwarding.
  logic              wb_v_q;
  row_t              wb_row_q;
  bits_t             wb_data_q;

  // Fill scan.
  col_t              px_q, gap_q;
  logic              prev_q, have_q, fill_on_q;
  bits_t             mask_q;
  ldsf_pkg::coord_t  fill_y_q;

  // Output register.
  logic              out_valid_q, out_last_q;
  ldsf_pkg::coord_t  out_x_q, out_y_q;
  ldsf_pkg::color_t  out_c_q;

  // Edge map memory.
  bits_t             edge_mem [GRID_HEIGHT];
  bits_t             rd_q;

  logic              in_acc, out_free, b_to_out, a_go, fill_go, row_ok;
  logic              mem_we, mem_re;
  row_t              mem_waddr, mem_raddr;
  bits_t             mem_wdata, fwd_base, merged;
  ldsf_pkg::coord_t  tx_sat, ty_sat, ax, ay, major, minor;
  logic signed [6:0] dx, dy;
  logic              xmaj;
  logic signed [8:0] e0, both0, e_next;
  logic              e_neg;
  ldsf_pkg::coord_t  step_x, step_y, nx, ny;
  logic              scan_m, scan_close;
  bits_t             range_mask, lowbit, mask_rest;
  col_t              low_idx;

  assign item_i.ready = (state_q == S_IDLE) && !b_fresh_q;
  assign in_acc       = item_i.valid && item_i.ready;

  assign out_free = !out_valid_q || pixel_o.ready;
  assign b_to_out = b_valid_q && out_free;
  assign a_go     = (state_q == S_LINE) && (!b_valid_q || b_to_out);
  assign fill_go  = (state_q == S_EMIT) && (mask_q != '0) && out_free && !b_valid_q;
  assign row_ok   = int'(item_i.y) < GRID_HEIGHT;

  // Move targets saturate to the grid.
  assign tx_sat = (int'(item_i.x) >= GRID_WIDTH)  ? ldsf_pkg::coord_t'(GRID_WIDTH - 1)
                                                   : item_i.x;
  assign ty_sat = (int'(item_i.y) >= GRID_HEIGHT) ? ldsf_pkg::coord_t'(GRID_HEIGHT - 1)
                                                   : item_i.y;

  // Line setup from the current point.
  assign dx    = $signed({1'b0, tx_sat}) - $signed({1'b0, cur_x_q});
  assign dy    = $signed({1'b0, ty_sat}) - $signed({1'b0, cur_y_q});
  assign ax    = dx[6] ? ldsf_pkg::coord_t'(-dx) : ldsf_pkg::coord_t'(dx);
  assign ay    = dy[6] ? ldsf_pkg::coord_t'(-dy) : ldsf_pkg::coord_t'(dy);
  assign xmaj  = ax > ay;
  assign major = xmaj ? ax : ay;
  assign minor = xmaj ? ay : ax;
  assign e0    = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
  assign both0 = $signed({2'b00, minor, 1'b0}) - $signed({2'b00, major, 1'b0});

  // One Bresenham step: the major axis always moves, the minor axis when the
  // error term is not negative.
  assign e_neg  = e_q[8];
  assign e_next = e_neg ? (e_q + $signed({2'b00, inc_q})) : (e_q + both_q);
  assign step_x = sx_nz_q ? (sx_neg_q ? '1 : ldsf_pkg::coord_t'(1)) : '0;
  assign step_y = sy_nz_q ? (sy_neg_q ? '1 : ldsf_pkg::coord_t'(1)) : '0;
  assign nx     = cur_x_q + ((xmaj_q || !e_neg)  ? step_x : '0);
  assign ny     = cur_y_q + ((!xmaj_q || !e_neg) ? step_y : '0);

  // Mark merge with forwarding of last cycle's write.
  assign fwd_base = (wb_v_q && (wb_row_q == row_t'(b_y_q))) ? wb_data_q : rd_q;
  assign merged   = fwd_base | (bits_t'(1) << col_t'(b_x_q));

  always_comb begin
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = b_fresh_q;
      mem_waddr = row_t'(b_y_q);
      mem_wdata = merged;
    end
  end

  assign mem_raddr = (state_q == S_LINE) ? row_t'(cur_y_q) : row_t'(item_i.y);
  assign mem_re    = a_go || (in_acc && (item_i.cmd == ldsf_pkg::CMD_FILL) && row_ok);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      edge_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= edge_mem[mem_raddr];
    end
  end

  // Column scan: a rising mark starts an edge; a rising mark after an edge
  // closes a gap, which is filled on every other closure.
  assign scan_m     = rd_q[px_q];
  assign scan_close = scan_m && !prev_q && have_q && fill_on_q;

  always_comb begin
    for (int j = 0; j < GRID_WIDTH; j++) begin
      range_mask[j] = (col_t'(j) >= gap_q) && (col_t'(j) < px_q);
    end
  end

  // Lowest remaining span pixel.
  assign lowbit    = mask_q & (~mask_q + bits_t'(1));
  assign mask_rest = mask_q & (mask_q - bits_t'(1));

  always_comb begin
    low_idx = '0;
    for (int j = 0; j < GRID_WIDTH; j++) begin
      if (lowbit[j]) begin
        low_idx = low_idx | col_t'(j);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      fill_color_q <= ldsf_pkg::RESET_FILL_COLOR;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      xmaj_q       <= 1'b0;
      sx_neg_q     <= 1'b0;
      sx_nz_q      <= 1'b0;
      sy_neg_q     <= 1'b0;
      sy_nz_q      <= 1'b0;
      inc_q        <= '0;
      both_q       <= '0;
      e_q          <= '0;
      cnt_q        <= '0;
      b_valid_q    <= 1'b0;
      b_fresh_q    <= 1'b0;
      b_last_q     <= 1'b0;
      b_x_q        <= '0;
      b_y_q        <= '0;
      wb_v_q       <= 1'b0;
      wb_row_q     <= '0;
      wb_data_q    <= '0;
      px_q         <= '0;
      gap_q        <= '0;
      prev_q       <= 1'b0;
      have_q       <= 1'b0;
      fill_on_q    <= 1'b0;
      mask_q       <= '0;
      fill_y_q     <= '0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
      out_x_q      <= '0;
      out_y_q      <= '0;
      out_c_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        fill_color_q <= cfg_wdata_i;
      end

      wb_v_q    <= mem_we;
      wb_row_q  <= mem_waddr;
      wb_data_q <= mem_wdata;

      // Mark stage: loaded by the stepper, drained into the output register.
      b_fresh_q <= a_go;
      if (a_go) begin
        b_valid_q <= 1'b1;
        b_x_q     <= cur_x_q;
        b_y_q     <= cur_y_q;
        b_last_q  <= (cnt_q == ldsf_pkg::coord_t'(1));
      end else if (b_to_out) begin
        b_valid_q <= 1'b0;
      end

      // Output register: line pixels first, then span pixels.
      if (b_to_out) begin
        out_valid_q <= 1'b1;
        out_x_q     <= b_x_q;
        out_y_q     <= b_y_q;
        out_c_q     <= ldsf_pkg::LINE_COLOR;
        out_last_q  <= b_last_q;
      end else if (fill_go) begin
        out_valid_q <= 1'b1;
        out_x_q     <= ldsf_pkg::coord_t'(low_idx);
        out_y_q     <= fill_y_q;
        out_c_q     <= fill_color_q;
        out_last_q  <= (mask_rest == '0);
      end else if (pixel_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (item_i.cmd)
              ldsf_pkg::CMD_MOVE: begin
                if (item_i.draw && (major != '0)) begin
                  xmaj_q   <= xmaj;
                  sx_neg_q <= dx[6];
                  sx_nz_q  <= (dx != '0);
                  sy_neg_q <= dy[6];
                  sy_nz_q  <= (dy != '0);
                  inc_q    <= {minor, 1'b0};
                  both_q   <= both0;
                  e_q      <= e0;
                  cnt_q    <= major;
                  state_q  <= S_LINE;
                end else begin
                  // Pen up, or a line to the current point.
                  cur_x_q <= tx_sat;
                  cur_y_q <= ty_sat;
                end
              end
              ldsf_pkg::CMD_FILL: begin
                if (row_ok) begin
                  px_q      <= '0;
                  gap_q     <= '0;
                  prev_q    <= 1'b0;
                  have_q    <= 1'b0;
                  fill_on_q <= 1'b1;
                  mask_q    <= '0;
                  fill_y_q  <= item_i.y;
                  state_q   <= S_SCAN;
                end
              end
              ldsf_pkg::CMD_CLEAR: begin
                clr_q   <= '0;
                state_q <= S_CLEAR;
              end
              default: begin
              end
            endcase
          end
        end

        S_CLEAR: begin
          if (clr_q == row_t'(GRID_HEIGHT - 1)) begin
            state_q <= S_IDLE;
          end else begin
            clr_q <= clr_q + row_t'(1);
          end
        end

        S_LINE: begin
          if (a_go) begin
            cur_x_q <= nx;
            cur_y_q <= ny;
            e_q     <= e_next;
            cnt_q   <= cnt_q - ldsf_pkg::coord_t'(1);
            if (cnt_q == ldsf_pkg::coord_t'(1)) begin
              state_q <= S_IDLE;
            end
          end
        end

        S_SCAN: begin
          if (scan_m && !prev_q) begin
            if (have_q) begin
              fill_on_q <= !fill_on_q;
            end
            have_q <= 1'b1;
          end
          if (scan_close) begin
            mask_q <= mask_q | range_mask;
          end
          if (!scan_m && prev_q) begin
            gap_q <= px_q;
          end
          prev_q <= scan_m;
          if (px_q == col_t'(GRID_WIDTH - 1)) begin
            state_q <= S_EMIT;
          end else begin
            px_q <= px_q + col_t'(1);
          end
        end

        S_EMIT: begin
          if (mask_q == '0) begin
            state_q <= S_IDLE;
          end else if (fill_go) begin
            mask_q <= mask_rest;
            if (mask_rest == '0) begin
              state_q <= S_IDLE;
            end
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign pixel_o.valid       = out_valid_q;
  assign pixel_o.pixel_x     = out_x_q;
  assign pixel_o.pixel_y     = out_y_q;
  assign pixel_o.pixel_color = out_c_q;
  assign pixel_o.last        = out_last_q;

  // An accepted transaction never coincides with an edge map write, so a fill
  // read issued at acceptance always sees the finished row.
  `ASSERT_IMPLIES(a_acc_no_write, clk_i, rst_ni, in_acc, !mem_we)
  // The merge cycle always belongs to a pixel held in the mark stage.
  `ASSERT_IMPLIES(a_fresh_held, clk_i, rst_ni, b_fresh_q, b_valid_q)
  // A stepper advance is followed by exactly one edge map write.
  `ASSERT_NEXT(a_go_writes, clk_i, rst_ni, a_go, mem_we && (state_q != S_CLEAR))
  // Marked rows stay inside the grid.
  `ASSERT_ALWAYS(a_row_in_grid, clk_i, rst_ni, !b_valid_q || (int'(b_y_q) < GRID_HEIGHT))

endmodule
